FILE: rtl/lcd_pkg.sv
// shared constants, types and fixed-point helpers for the lasso coordinate step
package lcd_pkg;

    localparam int RES_DEPTH   = 16384;
    localparam int COORD_DEPTH = 65536;
    localparam int COL_MAX     = 128;

    localparam int RES_AW   = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int COORD_AW = (COORD_DEPTH > 1) ? $clog2(COORD_DEPTH) : 1;
    localparam int COL_AW   = (COL_MAX > 1) ? $clog2(COL_MAX) : 1;
    localparam int COUNT_W  = $clog2(COL_MAX + 1);

    localparam int ROW_W   = 14;
    localparam int COORD_W = 16;

    typedef enum logic [1:0] {
        OP_RES_WRITE  = 2'd0,
        OP_ENTRY      = 2'd1,
        OP_RES_READ   = 2'd2,
        OP_COORD_READ = 2'd3
    } opcode_t;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic                     we;
        logic [RES_AW-1:0]        addr;
        logic signed [31:0]       wdata;
    } res_req_t;

    typedef struct packed {
        logic                     we;
        logic [COORD_AW-1:0]      addr;
        logic signed [31:0]       wdata;
    } coord_req_t;

    typedef struct packed {
        logic [ROW_W-1:0]         row;
        logic signed [31:0]       value;
    } col_entry_t;

    typedef struct packed {
        logic                     we;
        logic [COL_AW-1:0]        addr;
        col_entry_t               wdata;
    } col_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -65'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] round16(input logic signed [63:0] v);
        logic signed [63:0] c;
        logic signed [63:0] s;
        c = (v > 64'sh7fffffffffff7fff) ? 64'sh7fffffffffff7fff : v;
        s = (c + 64'sd32768) >>> 16;
        return sat32(65'(s));
    endfunction

    function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v == 32'sh80000000)
            r = 32'sh7fffffff;
        else
            r = -v;
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7fffffffffffffff)
            r = 64'sh7fffffffffffffff;
        else if (s < -65'sh0_8000000000000000)
            r = 64'sh8000000000000000;
        else
            r = s[63:0];
        return r;
    endfunction

endpackage

FILE: rtl/lcd_residual_ram.sv
// residual store, one synchronous read/write port
module lcd_residual_ram
    import lcd_pkg::*;
(
    input  logic               clk,
    input  res_req_t           req,
    output logic signed [31:0] rdata
);

    logic signed [31:0] mem [RES_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

endmodule

FILE: rtl/lcd_coord_ram.sv
// coordinate store with clearing pass after reset
module lcd_coord_ram
    import lcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  coord_req_t         req,
    output logic signed [31:0] rdata,
    output logic               ready
);

    logic signed [31:0]  mem [COORD_DEPTH];
    logic                clearing_reg;
    logic                clearing_next;
    logic [COORD_AW-1:0] clr_addr_reg;
    logic [COORD_AW-1:0] clr_addr_next;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (32'(clr_addr_reg) == COORD_DEPTH - 1)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

    assign ready = !clearing_reg;

endmodule

FILE: rtl/lcd_column_buf.sv
// buffer of the current column's entries
module lcd_column_buf
    import lcd_pkg::*;
(
    input  logic       clk,
    input  col_req_t   req,
    output col_entry_t rdata
);

    col_entry_t mem [COL_MAX];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

endmodule

FILE: rtl/lasso_coordinate_descent_step_core.sv
// top level: sequencer and datapath of the lasso coordinate step
//
//  port group       dir  handshake                fields
//  command          in   start & !busy            opcode coord_index row_index entry_value
//                                                 inv_lipschitz last_entry
//  config           in   penalty_weight_we        penalty_weight_wdata
//  result           out  result_valid, one cycle  result_kind coord_out step_delta data_out
//
//  after reset busy stays high while the coordinate store clears
//  residual write: busy stays low; reads pass through ST_READ_OUT to the result strobe
//  column entry: residual read, multiply, accumulate; not stored if the buffer is full
//  last entry adds the update states and a scatter of each buffered entry through the
//  residual memory port and the shared multiplier; results cannot be stalled
module lasso_coordinate_descent_step_core
    import lcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [15:0]         coord_index,
    input  logic [13:0]         row_index,
    input  logic signed [31:0]  entry_value,
    input  logic [30:0]         inv_lipschitz,
    input  logic                last_entry,
    input  logic                penalty_weight_we,
    input  logic [30:0]         penalty_weight_wdata,
    output logic                result_valid,
    output logic                result_kind,
    output logic [15:0]         coord_out,
    output logic signed [31:0]  step_delta,
    output logic signed [31:0]  data_out
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_READ_OUT, ST_ENT_MUL, ST_ENT_ACC,
        ST_UPD_T, ST_UPD_S, ST_UPD_MP, ST_UPD_MM, ST_UPD_TH, ST_UPD_DEC, ST_UPD_WX,
        ST_SC_RD, ST_SC_RES, ST_SC_MUL, ST_SC_RND, ST_SC_WR, ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  k_reg, k_next;
    logic signed [63:0]  acc_reg, acc_next;
    logic [30:0]         lambda_reg, lambda_next;
    opcode_t             op_reg, op_next;
    logic [15:0]         coord_reg, coord_next;
    logic [13:0]         row_reg, row_next;
    logic signed [31:0]  val_reg, val_next;
    logic [30:0]         li_reg, li_next;
    logic                last_reg, last_next;
    logic                row_ok_reg, row_ok_next;
    logic                coord_ok_reg, coord_ok_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic signed [31:0]  t_reg, t_next;
    logic signed [31:0]  sp_reg, sp_next;
    logic signed [31:0]  sm_reg, sm_next;
    logic signed [31:0]  x_reg, x_next;
    logic signed [31:0]  thp_reg, thp_next;
    logic signed [31:0]  thm_reg, thm_next;
    logic signed [31:0]  delta_reg, delta_next;
    logic signed [31:0]  xnew_reg, xnew_next;
    logic signed [31:0]  res_reg, res_next;
    logic signed [31:0]  inc_reg, inc_next;
    logic                result_valid_reg, result_valid_next;
    logic                result_kind_reg, result_kind_next;
    logic [15:0]         coord_out_reg, coord_out_next;
    logic signed [31:0]  step_delta_reg, step_delta_next;
    logic signed [31:0]  data_out_reg, data_out_next;

    res_req_t            res_req;
    coord_req_t          coord_req;
    col_req_t            col_req;
    logic signed [31:0]  res_rdata;
    logic signed [31:0]  coord_rdata;
    col_entry_t          col_rdata;
    logic                coord_ready;

    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  mul_p;
    logic signed [64:0]  lam_ext;
    logic                accept;
    logic                in_row_ok;
    logic                in_coord_ok;

    lcd_residual_ram u_res (
        .clk   (clk),
        .req   (res_req),
        .rdata (res_rdata)
    );

    lcd_coord_ram u_coord (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (coord_req),
        .rdata (coord_rdata),
        .ready (coord_ready)
    );

    lcd_column_buf u_col (
        .clk   (clk),
        .req   (col_req),
        .rdata (col_rdata)
    );

    assign busy        = (state_reg != ST_IDLE) || !coord_ready;
    assign accept      = start && !busy;
    assign in_row_ok   = 32'(row_index) < RES_DEPTH;
    assign in_coord_ok = 32'(coord_index) < COORD_DEPTH;
    assign lam_ext     = 65'($signed({1'b0, lambda_reg}));
    assign mul_p       = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ENT_MUL:
            begin
                mul_a = val_reg;
                mul_b = row_ok_reg ? res_rdata : 32'sd0;
            end
            ST_UPD_MP:
            begin
                mul_a = $signed({1'b0, li_reg});
                mul_b = sp_reg;
            end
            ST_UPD_MM:
            begin
                mul_a = $signed({1'b0, li_reg});
                mul_b = sm_reg;
            end
            ST_SC_MUL:
            begin
                mul_a = delta_reg;
                mul_b = val_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        k_next            = k_reg;
        acc_next          = acc_reg;
        lambda_next       = penalty_weight_we ? penalty_weight_wdata : lambda_reg;
        op_next           = op_reg;
        coord_next        = coord_reg;
        row_next          = row_reg;
        val_next          = val_reg;
        li_next           = li_reg;
        last_next         = last_reg;
        row_ok_next       = row_ok_reg;
        coord_ok_next     = coord_ok_reg;
        prod_next         = prod_reg;
        t_next            = t_reg;
        sp_next           = sp_reg;
        sm_next           = sm_reg;
        x_next            = x_reg;
        thp_next          = thp_reg;
        thm_next          = thm_reg;
        delta_next        = delta_reg;
        xnew_next         = xnew_reg;
        res_next          = res_reg;
        inc_next          = inc_reg;
        result_valid_next = 1'b0;
        result_kind_next  = result_kind_reg;
        coord_out_next    = coord_out_reg;
        step_delta_next   = step_delta_reg;
        data_out_next     = data_out_reg;

        res_req.we      = 1'b0;
        res_req.addr    = row_index[RES_AW-1:0];
        res_req.wdata   = entry_value;
        coord_req.we    = 1'b0;
        coord_req.addr  = coord_index[COORD_AW-1:0];
        coord_req.wdata = '0;
        col_req.we      = 1'b0;
        col_req.addr    = count_reg[COL_AW-1:0];
        col_req.wdata   = '{row: row_index, value: entry_value};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = opcode_t'(opcode);
                    coord_next    = coord_index;
                    row_next      = row_index;
                    val_next      = entry_value;
                    li_next       = inv_lipschitz;
                    last_next     = last_entry;
                    row_ok_next   = in_row_ok;
                    coord_ok_next = in_coord_ok;
                    case (opcode_t'(opcode))
                        OP_RES_WRITE:
                        begin
                            res_req.we = in_row_ok;
                        end
                        OP_ENTRY:
                        begin
                            if (32'(count_reg) < COL_MAX)
                            begin
                                col_req.we = 1'b1;
                                count_next = count_reg + 1'b1;
                                state_next = ST_ENT_MUL;
                            end
                            else if (last_entry)
                            begin
                                state_next = ST_UPD_T;
                            end
                        end
                        OP_RES_READ, OP_COORD_READ:
                        begin
                            state_next = ST_READ_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ_OUT:
            begin
                result_valid_next = 1'b1;
                result_kind_next  = KIND_READ;
                step_delta_next   = '0;
                if (op_reg == OP_COORD_READ)
                begin
                    coord_out_next = coord_reg;
                    data_out_next  = coord_ok_reg ? coord_rdata : 32'sd0;
                end
                else
                begin
                    coord_out_next = '0;
                    data_out_next  = row_ok_reg ? res_rdata : 32'sd0;
                end
                state_next = ST_IDLE;
            end
            ST_ENT_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_ENT_ACC;
            end
            ST_ENT_ACC:
            begin
                acc_next   = sat_add64(acc_reg, prod_reg);
                state_next = last_reg ? ST_UPD_T : ST_IDLE;
            end
            ST_UPD_T:
            begin
                t_next         = round16(acc_reg);
                coord_req.addr = coord_reg[COORD_AW-1:0];
                state_next     = ST_UPD_S;
            end
            ST_UPD_S:
            begin
                sp_next    = sat32(65'(t_reg) + lam_ext);
                sm_next    = sat32(65'(t_reg) - lam_ext);
                x_next     = coord_ok_reg ? coord_rdata : 32'sd0;
                state_next = ST_UPD_MP;
            end
            ST_UPD_MP:
            begin
                prod_next  = mul_p;
                state_next = ST_UPD_MM;
            end
            ST_UPD_MM:
            begin
                thp_next   = round16(prod_reg);
                prod_next  = mul_p;
                state_next = ST_UPD_TH;
            end
            ST_UPD_TH:
            begin
                thm_next   = round16(prod_reg);
                state_next = ST_UPD_DEC;
            end
            ST_UPD_DEC:
            begin
                if (x_reg > thp_reg)
                    delta_next = neg32(thp_reg);
                else if (x_reg < thm_reg)
                    delta_next = neg32(thm_reg);
                else
                    delta_next = neg32(x_reg);
                state_next = ST_UPD_WX;
            end
            ST_UPD_WX:
            begin
                xnew_next       = sat32(65'(x_reg) + 65'(delta_reg));
                coord_req.we    = coord_ok_reg;
                coord_req.addr  = coord_reg[COORD_AW-1:0];
                coord_req.wdata = xnew_next;
                k_next          = '0;
                state_next      = (count_reg == '0) ? ST_DONE : ST_SC_RD;
            end
            ST_SC_RD:
            begin
                col_req.addr = k_reg[COL_AW-1:0];
                state_next   = ST_SC_RES;
            end
            ST_SC_RES:
            begin
                row_next     = col_rdata.row;
                val_next     = col_rdata.value;
                row_ok_next  = 32'(col_rdata.row) < RES_DEPTH;
                res_req.addr = col_rdata.row[RES_AW-1:0];
                state_next   = ST_SC_MUL;
            end
            ST_SC_MUL:
            begin
                res_next   = res_rdata;
                prod_next  = mul_p;
                state_next = ST_SC_RND;
            end
            ST_SC_RND:
            begin
                inc_next   = round16(prod_reg);
                state_next = ST_SC_WR;
            end
            ST_SC_WR:
            begin
                res_req.we    = row_ok_reg;
                res_req.addr  = row_reg[RES_AW-1:0];
                res_req.wdata = sat32(65'(res_reg) + 65'(inc_reg));
                k_next        = k_reg + 1'b1;
                state_next    = (k_next == count_reg) ? ST_DONE : ST_SC_RD;
            end
            ST_DONE:
            begin
                result_valid_next = 1'b1;
                result_kind_next  = KIND_UPDATE;
                coord_out_next    = coord_reg;
                step_delta_next   = delta_reg;
                data_out_next     = xnew_reg;
                count_next        = '0;
                acc_next          = '0;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            k_reg            <= '0;
            acc_reg          <= '0;
            lambda_reg       <= 31'd65536;
            op_reg           <= OP_RES_WRITE;
            coord_reg        <= '0;
            row_reg          <= '0;
            val_reg          <= '0;
            li_reg           <= '0;
            last_reg         <= 1'b0;
            row_ok_reg       <= 1'b0;
            coord_ok_reg     <= 1'b0;
            prod_reg         <= '0;
            t_reg            <= '0;
            sp_reg           <= '0;
            sm_reg           <= '0;
            x_reg            <= '0;
            thp_reg          <= '0;
            thm_reg          <= '0;
            delta_reg        <= '0;
            xnew_reg         <= '0;
            res_reg          <= '0;
            inc_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_kind_reg  <= KIND_UPDATE;
            coord_out_reg    <= '0;
            step_delta_reg   <= '0;
            data_out_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            k_reg            <= k_next;
            acc_reg          <= acc_next;
            lambda_reg       <= lambda_next;
            op_reg           <= op_next;
            coord_reg        <= coord_next;
            row_reg          <= row_next;
            val_reg          <= val_next;
            li_reg           <= li_next;
            last_reg         <= last_next;
            row_ok_reg       <= row_ok_next;
            coord_ok_reg     <= coord_ok_next;
            prod_reg         <= prod_next;
            t_reg            <= t_next;
            sp_reg           <= sp_next;
            sm_reg           <= sm_next;
            x_reg            <= x_next;
            thp_reg          <= thp_next;
            thm_reg          <= thm_next;
            delta_reg        <= delta_next;
            xnew_reg         <= xnew_next;
            res_reg          <= res_next;
            inc_reg          <= inc_next;
            result_valid_reg <= result_valid_next;
            result_kind_reg  <= result_kind_next;
            coord_out_reg    <= coord_out_next;
            step_delta_reg   <= step_delta_next;
            data_out_reg     <= data_out_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = result_kind_reg;
    assign coord_out    = coord_out_reg;
    assign step_delta   = step_delta_reg;
    assign data_out     = data_out_reg;

endmodule
